FILE: sv/pcls_pkg.sv
// ----------------------------------------------------------------------------
// pcls_pkg
// Shared types and constants for the L3/L4 header classifier: EtherType and
// protocol codes, class codes, header lengths and the per-frame record.
// ----------------------------------------------------------------------------
package pcls_pkg;

  // frame parsing
  localparam int unsigned POS_W = 7;
  localparam logic [POS_W-1:0] POS_MAX = 7'd127;

  // header byte positions
  localparam logic [POS_W-1:0] POS_TYPE_HI       = 7'd12;
  localparam logic [POS_W-1:0] POS_TYPE_LO       = 7'd13;
  localparam logic [POS_W-1:0] POS_INNER_TYPE_HI = 7'd16;
  localparam logic [POS_W-1:0] POS_INNER_TYPE_LO = 7'd17;
  localparam logic [POS_W-1:0] L2_LEN_UNTAGGED   = 7'd14;
  localparam logic [POS_W-1:0] L2_LEN_TAGGED     = 7'd18;
  localparam logic [POS_W-1:0] IPV4_PROTO_OFS    = 7'd9;
  localparam logic [POS_W-1:0] IPV6_NEXT_OFS     = 7'd6;

  // header lengths
  localparam int unsigned HDR_W = 7;
  localparam logic [HDR_W-1:0] IPV4_HDR_LEN = 7'd20;
  localparam logic [HDR_W-1:0] IPV6_HDR_LEN = 7'd40;
  localparam logic [HDR_W-1:0] TCP_HDR_LEN  = 7'd20;
  localparam logic [HDR_W-1:0] UDP_HDR_LEN  = 7'd8;

  // EtherType and protocol codes
  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // counters
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned OUT_CNT_W      = 32;
  localparam int unsigned NUM_CNT        = 6;
  localparam int unsigned CNT_TOTAL      = 0;
  localparam int unsigned CNT_VLAN       = 1;
  localparam int unsigned CNT_IPV4       = 2;
  localparam int unsigned CNT_IPV6       = 3;
  localparam int unsigned CNT_TCP        = 4;
  localparam int unsigned CNT_UDP        = 5;

  // record queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    L3_IPV4  = 2'd0,
    L3_IPV6  = 2'd1,
    L3_OTHER = 2'd2
  } l3_class_e;

  typedef enum logic [1:0] {
    L4_TCP   = 2'd0,
    L4_UDP   = 2'd1,
    L4_OTHER = 2'd2,
    L4_NONE  = 2'd3
  } l4_class_e;

  // one classified frame, front to back
  typedef struct packed {
    logic             keep;
    logic             vlan;
    l3_class_e        l3c;
    l4_class_e        l4c;
    logic [HDR_W-1:0] hdr;
  } cls_rec_t;

endpackage

FILE: sv/pcls_front.sv
// ----------------------------------------------------------------------------
// pcls_front
// Byte-wise header parser. Tracks the byte position, captures the EtherType
// (outer and, when tagged, inner) and the L4 protocol byte, and on the last
// byte of a frame pushes one classified record into the queue.
// ----------------------------------------------------------------------------
module pcls_front
  import pcls_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cls_rec_t   q_rec_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      etype_q, etype_d;
  logic             tag_q, tag_d;
  logic [7:0]       proto_q, proto_d;
  logic             pcap_q, pcap_d;
  logic             accept;
  logic [POS_W-1:0] l3off;
  logic [POS_W-1:0] l2len;
  logic             have_type;
  cls_rec_t         rec;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept && last_byte_i;
  assign q_rec_o    = rec;

  // field capture for the current beat
  always_comb begin
    etype_d = etype_q;
    tag_d   = tag_q;
    proto_d = proto_q;
    pcap_d  = pcap_q;
    l3off   = tag_q ? L2_LEN_TAGGED : L2_LEN_UNTAGGED;

    if (pos_q == POS_TYPE_HI || (tag_q && pos_q == POS_INNER_TYPE_HI)) begin
      etype_d = {data_byte_i, etype_q[7:0]};
    end else if (pos_q == POS_TYPE_LO || (tag_q && pos_q == POS_INNER_TYPE_LO)) begin
      etype_d = {etype_q[15:8], data_byte_i};
      if (pos_q == POS_TYPE_LO && etype_d == TYPE_VLAN) begin
        tag_d = 1'b1;
      end
    end

    if (pos_q >= l3off && !pcap_q) begin
      if ((etype_d == TYPE_IPV4 && pos_q == l3off + IPV4_PROTO_OFS) ||
          (etype_d == TYPE_IPV6 && pos_q == l3off + IPV6_NEXT_OFS)) begin
        proto_d = data_byte_i;
        pcap_d  = 1'b1;
      end
    end

    pos_d = (pos_q == POS_MAX) ? POS_MAX : pos_q + 7'd1;
  end

  // frame classification, used on the last beat
  always_comb begin
    l2len     = tag_d ? L2_LEN_TAGGED : L2_LEN_UNTAGGED;
    have_type = pos_d >= l2len;
    rec.keep  = 1'b0;
    rec.vlan  = tag_d;
    rec.l3c   = L3_OTHER;
    rec.l4c   = L4_NONE;
    rec.hdr   = '0;

    if (have_type && etype_d == TYPE_IPV4) begin
      rec.l3c = L3_IPV4;
    end else if (have_type && etype_d == TYPE_IPV6) begin
      rec.l3c = L3_IPV6;
    end

    if (rec.l3c != L3_OTHER) begin
      rec.l4c = L4_OTHER;
      if (pcap_d && proto_d == PROTO_TCP) begin
        rec.l4c = L4_TCP;
      end else if (pcap_d && proto_d == PROTO_UDP) begin
        rec.l4c = L4_UDP;
      end
      if (rec.l4c == L4_TCP || rec.l4c == L4_UDP) begin
        rec.keep = 1'b1;
        rec.hdr  = l2len
                 + ((rec.l3c == L3_IPV4) ? IPV4_HDR_LEN : IPV6_HDR_LEN)
                 + ((rec.l4c == L4_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN);
      end
    end
  end

  // per-frame state, cleared after the last beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      etype_q <= '0;
      tag_q   <= 1'b0;
      proto_q <= '0;
      pcap_q  <= 1'b0;
    end else if (accept) begin
      if (last_byte_i) begin
        pos_q   <= '0;
        etype_q <= '0;
        tag_q   <= 1'b0;
        proto_q <= '0;
        pcap_q  <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        etype_q <= etype_d;
        tag_q   <= tag_d;
        proto_q <= proto_d;
        pcap_q  <= pcap_d;
      end
    end
  end

endmodule

FILE: sv/pcls_queue.sv
// ----------------------------------------------------------------------------
// pcls_queue
// Short record queue between the parser and the counter stage, so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module pcls_queue
  import pcls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cls_rec_t push_rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output cls_rec_t pop_rec_o
);

  cls_rec_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;

  assign full_o    = (count_q == QUEUE_DEPTH[QUEUE_PTR_W:0]);
  assign empty_o   = (count_q == '0);
  assign pop_rec_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/pcls_back.sv
// ----------------------------------------------------------------------------
// pcls_back
// Counter and output stage. Takes one record from the queue per cycle when
// the output register is free or being drained, bumps the class counters
// and presents the result beat.
// ----------------------------------------------------------------------------
module pcls_back
  import pcls_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  cls_rec_t             q_rec_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cls_rec_t             out_rec_o,
  output logic [COUNT_BITS-1:0] cnt_o [NUM_CNT]
);

  logic                  out_valid_q;
  cls_rec_t              out_rec_q;
  logic [COUNT_BITS-1:0] cnt_q [NUM_CNT];
  logic [NUM_CNT-1:0]    bump;

  assign q_pop_o     = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;
  assign cnt_o       = cnt_q;

  // which counters this record advances
  always_comb begin
    bump            = '0;
    bump[CNT_TOTAL] = 1'b1;
    bump[CNT_VLAN]  = q_rec_i.vlan;
    bump[CNT_IPV4]  = (q_rec_i.l3c == L3_IPV4);
    bump[CNT_IPV6]  = (q_rec_i.l3c == L3_IPV6);
    bump[CNT_TCP]   = (q_rec_i.l4c == L4_TCP);
    bump[CNT_UDP]   = (q_rec_i.l4c == L4_UDP);
  end

  // class counters, wrapping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (q_pop_o) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        if (bump[i]) begin
          cnt_q[i] <= cnt_q[i] + 1'b1;
        end
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_rec_q <= q_rec_i;
    end
  end

endmodule

FILE: sv/packet_l3_l4_classifier.sv
// ----------------------------------------------------------------------------
// packet_l3_l4_classifier
// Ethernet / 802.1Q / IPv4 / IPv6 / TCP / UDP header classifier with running
// per-class frame counters.
// ----------------------------------------------------------------------------
// Frame bytes enter one beat per clock in wire order, with last_byte_i on the
// final byte. The block takes a byte every cycle; the parser runs in step with
// the input and only pauses when the four-entry record queue is full. Each
// frame gives one result beat: the record is first written into the queue,
// then the counter stage loads the output register and the counters together.
// Counters are COUNT_BITS wide and wrap. The 32-bit ports show their low bits,
// zero-extended when COUNT_BITS is under 32.
// ----------------------------------------------------------------------------
module packet_l3_l4_classifier
  import pcls_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 keep_packet_o,
  output logic                 vlan_tagged_o,
  output logic [1:0]           l3_class_o,
  output logic [1:0]           l4_class_o,
  output logic [HDR_W-1:0]     header_bytes_o,
  output logic [OUT_CNT_W-1:0] total_count_o,
  output logic [OUT_CNT_W-1:0] vlan_count_o,
  output logic [OUT_CNT_W-1:0] ipv4_count_o,
  output logic [OUT_CNT_W-1:0] ipv6_count_o,
  output logic [OUT_CNT_W-1:0] tcp_count_o,
  output logic [OUT_CNT_W-1:0] udp_count_o
);

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_empty;
  cls_rec_t              push_rec;
  cls_rec_t              pop_rec;
  cls_rec_t              out_rec;
  logic [COUNT_BITS-1:0] cnt [NUM_CNT];
  logic [OUT_CNT_W-1:0]  cnt_out [NUM_CNT];

  // parser
  pcls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_rec_o     (push_rec)
  );

  // record queue
  pcls_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_rec_o  (pop_rec)
  );

  // counters and output register
  pcls_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_rec_i     (pop_rec),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rec_o   (out_rec),
    .cnt_o       (cnt)
  );

  // counter view on the fixed-width ports
  for (genvar g = 0; g < NUM_CNT; g++) begin : g_cnt
    if (COUNT_BITS >= OUT_CNT_W) begin : g_trunc
      assign cnt_out[g] = cnt[g][OUT_CNT_W-1:0];
    end else begin : g_ext
      assign cnt_out[g] = {{(OUT_CNT_W-COUNT_BITS){1'b0}}, cnt[g]};
    end
  end

  assign keep_packet_o  = out_rec.keep;
  assign vlan_tagged_o  = out_rec.vlan;
  assign l3_class_o     = out_rec.l3c;
  assign l4_class_o     = out_rec.l4c;
  assign header_bytes_o = out_rec.hdr;
  assign total_count_o  = cnt_out[CNT_TOTAL];
  assign vlan_count_o   = cnt_out[CNT_VLAN];
  assign ipv4_count_o   = cnt_out[CNT_IPV4];
  assign ipv6_count_o   = cnt_out[CNT_IPV6];
  assign tcp_count_o    = cnt_out[CNT_TCP];
  assign udp_count_o    = cnt_out[CNT_UDP];

endmodule
